FILE: sv/plp_pkg.sv
// Shared types, codes and default sizes for the positional insert/delete list.
`timescale 1ns / 1ps
`default_nettype none
package plp_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH         = 2;

  // Action codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [3:0] {
    OP_INSERT = 4'b0001,
    OP_APPEND = 4'b0010,
    OP_DELETE = 4'b0100,
    OP_READ   = 4'b1000
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: sv/plp_front.sv
// Front stage: accepts input transactions and classifies the action.
`timescale 1ns / 1ps
`default_nettype none
module plp_front #(
  parameter int PW = 7,
  parameter int CW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           action,
  input  wire logic [PW-1:0]        position,
  input  wire logic signed [CW-1:0] coord_x,
  input  wire logic signed [CW-1:0] coord_y,
  output logic                      f_valid,
  input  wire logic                 q_full,
  output plp_pkg::op_t              f_op,
  output logic [PW-1:0]             f_pos,
  output logic [CW-1:0]             f_x,
  output logic [CW-1:0]             f_y
);
  import plp_pkg::*;

  op_t op_dec;

  always_comb begin
    unique case (action)
      ACT_INSERT: op_dec = OP_INSERT;
      ACT_APPEND: op_dec = OP_APPEND;
      ACT_DELETE: op_dec = OP_DELETE;
      ACT_READ:   op_dec = OP_READ;
      default:    op_dec = OP_READ;
    endcase
  end

  // The held command leaves whenever the queue has room, so the stage only
  // stalls while it holds a command and the queue is full.
  assign in_stall = f_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_op  <= op_dec;
      f_pos <= position;
      f_x   <= coord_x;
      f_y   <= coord_y;
    end
  end

endmodule
`default_nettype wire

FILE: sv/plp_queue.sv
// Short command queue between the front stage and the list back end.
`timescale 1ns / 1ps
`default_nettype none
module plp_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  output logic                  q_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata
);
  import plp_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == QCW'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: sv/plp_back.sv
// Back end: a row of shifting cells that holds the list, plus the result register.
`timescale 1ns / 1ps
`default_nettype none
module plp_back #(
  parameter int DEPTH = 64,
  parameter int PW    = 7,
  parameter int CW    = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire plp_pkg::op_t         q_op,
  input  wire logic [PW-1:0]        q_pos,
  input  wire logic [CW-1:0]        q_x,
  input  wire logic [CW-1:0]        q_y,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [CW-1:0]      read_x,
  output logic signed [CW-1:0]      read_y,
  output logic [PW-1:0]             entry_count,
  output logic [1:0]                status
);
  import plp_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CW-1:0] x_store [DEPTH];
  logic [CW-1:0] y_store [DEPTH];
  logic [PW-1:0] count;
  logic [PW-1:0] count_next;
  logic [PW-1:0] eff_pos;
  logic          is_ins;
  logic          do_ins;
  logic          do_del;
  status_t       st;
  logic [CW-1:0] res_x;
  logic [CW-1:0] res_y;

  // A new command is taken whenever the result register is free or drains now.
  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    is_ins  = (q_op == OP_INSERT) || (q_op == OP_APPEND);
    eff_pos = (q_op == OP_APPEND) ? count : q_pos;
    if (is_ins) begin
      priority if (eff_pos > count) begin
        st = ST_RANGE;
      end else if (count == PW'(DEPTH)) begin
        st = ST_FULL;
      end else begin
        st = ST_DONE;
      end
    end else if (q_pos >= count) begin
      st = ST_RANGE;
    end else begin
      st = ST_DONE;
    end
    do_ins = q_pop && is_ins && (st == ST_DONE);
    do_del = q_pop && (q_op == OP_DELETE) && (st == ST_DONE);
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_del) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
    if ((q_op == OP_READ) && (st == ST_DONE)) begin
      res_x = x_store[q_pos[AW-1:0]];
      res_y = y_store[q_pos[AW-1:0]];
    end else begin
      res_x = '0;
      res_y = '0;
    end
  end

  // Each cell compares its own slot with the position and moves locally.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(i);
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_ins && IDX == eff_pos) begin
          x_store[i] <= q_x;
          y_store[i] <= q_y;
        end else if (do_del && IDX >= q_pos) begin
          x_store[i] <= x_store[i+1];
          y_store[i] <= y_store[i+1];
        end
      end
    end else if (i == DEPTH - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (do_ins && IDX == eff_pos) begin
          x_store[i] <= q_x;
          y_store[i] <= q_y;
        end else if (do_ins && IDX > eff_pos) begin
          x_store[i] <= x_store[i-1];
          y_store[i] <= y_store[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (do_ins && IDX == eff_pos) begin
          x_store[i] <= q_x;
          y_store[i] <= q_y;
        end else if (do_ins && IDX > eff_pos) begin
          x_store[i] <= x_store[i-1];
          y_store[i] <= y_store[i-1];
        end else if (do_del && IDX >= q_pos) begin
          x_store[i] <= x_store[i+1];
          y_store[i] <= y_store[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      read_x      <= res_x;
      read_y      <= res_y;
      entry_count <= count_next;
      status      <= st;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(DEPTH))
    else $error("list count exceeds its depth");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    q_pop && st != ST_DONE |=> count == $past(count))
    else $error("rejected operation changed the count");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> count == PW'($past(count) + 1'b1))
    else $error("insert did not grow the list by one");

  a_del_shrink: assert property (@(posedge clk) disable iff (rst)
    do_del |=> count == PW'($past(count) - 1'b1))
    else $error("delete did not shrink the list by one");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_op != OP_READ |=> read_x == '0 && read_y == '0 && out_valid)
    else $error("non-read result carries coordinate data");

endmodule
`default_nettype wire

FILE: sv/positional_insert_delete_list.sv
// Top level of the positional insert/delete list of coordinate pairs.
//
// Usage: the input channel (in_valid/in_stall) carries one transaction per item:
// action (insert at position, append, delete at position, read at position),
// position and the coordinate pair. Every accepted transaction yields exactly
// one result transaction on the output channel (out_valid/out_stall) with the
// read pair (zero unless a successful read), the entry count after the
// operation and a status (done, position out of range, list full).
// A rejected operation leaves the list unchanged.
// Path of an item: front register, command queue, then the result register.
// Throughput: one item per cycle while out_stall is low; each list cell moves
// its pair locally, so an insert or delete anywhere updates all cells at once.
// A front register and a two-entry command queue part the input from the
// back end; a stalled output holds its result and the front register and the
// queue together absorb up to three further items before in_stall rises.
// Reset clears the count (empty list) and all valid flags; stored pairs are
// left as they are and are never visible until written again.
`timescale 1ns / 1ps
`default_nettype none
module positional_insert_delete_list #(
  parameter int DEPTH       = plp_pkg::DEPTH_DEFAULT,
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             action,
  input  wire logic [$clog2(DEPTH+1)-1:0]             position,
  input  wire logic signed [COORD_WIDTH-1:0]          coord_x,
  input  wire logic signed [COORD_WIDTH-1:0]          coord_y,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [COORD_WIDTH-1:0]               read_x,
  output logic signed [COORD_WIDTH-1:0]               read_y,
  output logic [$clog2(DEPTH+1)-1:0]                  entry_count,
  output logic [1:0]                                  status
);
  import plp_pkg::*;

  localparam int PW  = $clog2(DEPTH + 1);
  localparam int OPW = $bits(op_t);
  localparam int QW  = OPW + PW + 2 * COORD_WIDTH;

  logic                   f_valid;
  logic                   q_full;
  op_t                    f_op;
  logic [PW-1:0]          f_pos;
  logic [COORD_WIDTH-1:0] f_x;
  logic [COORD_WIDTH-1:0] f_y;
  logic [QW-1:0]          q_wdata;
  logic [QW-1:0]          q_rdata;
  logic                   q_valid;
  logic                   q_pop;
  op_t                    q_op;
  logic [PW-1:0]          q_pos;
  logic [COORD_WIDTH-1:0] q_x;
  logic [COORD_WIDTH-1:0] q_y;

  plp_front #(
    .PW (PW),
    .CW (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .position (position),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .f_valid  (f_valid),
    .q_full   (q_full),
    .f_op     (f_op),
    .f_pos    (f_pos),
    .f_x      (f_x),
    .f_y      (f_y)
  );

  assign q_wdata = {f_op, f_pos, f_x, f_y};

  plp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_valid),
    .wdata   (q_wdata),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (q_pop),
    .rdata   (q_rdata)
  );

  assign q_op  = op_t'(q_rdata[QW-1 -: OPW]);
  assign q_pos = q_rdata[2*COORD_WIDTH +: PW];
  assign q_x   = q_rdata[COORD_WIDTH +: COORD_WIDTH];
  assign q_y   = q_rdata[0 +: COORD_WIDTH];

  plp_back #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .CW    (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_op        (q_op),
    .q_pos       (q_pos),
    .q_x         (q_x),
    .q_y         (q_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_x      (read_x),
    .read_y      (read_y),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule
`default_nettype wire

FILE: tb/plp_list_checker.sv
// Checker for the positional list: predicts every result and compares it with the DUT output.
`timescale 1ns / 1ps
module plp_list_checker #(
  parameter int DEPTH       = plp_pkg::DEPTH_DEFAULT,
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [$clog2(DEPTH+1)-1:0]          position,
  input  logic signed [COORD_WIDTH-1:0]       coord_x,
  input  logic signed [COORD_WIDTH-1:0]       coord_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [COORD_WIDTH-1:0]       read_x,
  input  logic signed [COORD_WIDTH-1:0]       read_y,
  input  logic [$clog2(DEPTH+1)-1:0]          entry_count,
  input  logic [1:0]                          status,
  output int                                  fail_count,
  output int                                  pending
);
  import plp_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [PW-1:0]                 cnt;
    status_t                       st;
  } list_result_t;

  logic signed [COORD_WIDTH-1:0] x_list [DEPTH];
  logic signed [COORD_WIDTH-1:0] y_list [DEPTH];
  int unsigned                   held;
  list_result_t                  expected_results [$];
  int                            errors = 0;

  // Applies one operation to the mirrored list and returns the result it should give.
  function automatic list_result_t apply_list_op(action_t act, int unsigned pos,
                                                 logic [COORD_WIDTH-1:0] cx,
                                                 logic [COORD_WIDTH-1:0] cy);
    list_result_t r;
    int unsigned  slot;
    int unsigned  k;
    r    = '0;
    r.st = ST_DONE;
    slot = pos;
    case (act)
      ACT_INSERT, ACT_APPEND: begin
        if (act == ACT_APPEND) slot = held;
        // The position check takes priority over the full check.
        if (slot > held) begin
          r.st = ST_RANGE;
        end else if (held >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (k = held; k > slot; k--) begin
            x_list[k] = x_list[k-1];
            y_list[k] = y_list[k-1];
          end
          x_list[slot] = cx;
          y_list[slot] = cy;
          held++;
        end
      end
      ACT_DELETE: begin
        if (slot >= held) begin
          r.st = ST_RANGE;
        end else begin
          for (k = slot; k + 1 < held; k++) begin
            x_list[k] = x_list[k+1];
            y_list[k] = y_list[k+1];
          end
          held--;
        end
      end
      default: begin
        if (slot >= held) begin
          r.st = ST_RANGE;
        end else begin
          r.x = x_list[slot];
          r.y = y_list[slot];
        end
      end
    endcase
    r.cnt = held[PW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      held = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: result with nothing expected: x=%0d y=%0d cnt=%0d st=%0d",
                     $time, read_x, read_y, entry_count, status);
        end else begin
          want = expected_results.pop_front();
          if (read_x !== want.x || read_y !== want.y || entry_count !== want.cnt ||
              status !== want.st) begin
            errors++;
            if (errors <= 20)
              $display("%0t: expected x=%0d y=%0d c=%0d s=%0d, got x=%0d y=%0d c=%0d s=%0d",
                       $time, want.x, want.y, want.cnt, want.st,
                       read_x, read_y, entry_count, status);
          end
        end
      end
      // A result accepted on this edge always belongs to an older transaction.
      if (in_valid && !in_stall)
        expected_results.push_back(apply_list_op(action_t'(action), position,
                                                 coord_x, coord_y));
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the positional list: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import plp_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CW          = 32;
  localparam int PW          = $clog2(DEPTH + 1);
  localparam int NUM_ITEMS   = 500;
  localparam int IDLE_LIMIT  = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = ACT_READ;
  logic [PW-1:0]        position = '0;
  logic signed [CW-1:0] coord_x = '0;
  logic signed [CW-1:0] coord_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] read_x;
  logic signed [CW-1:0] read_y;
  logic [PW-1:0]        entry_count;
  logic [1:0]           status;
  int                   fail_count;
  int                   pending;

  bit                   calm = 1'b0;
  int                   stall_left = 0;
  int                   idle_cycles = 0;
  int unsigned          list_len = 0;
  int                   sent = 0;

  positional_insert_delete_list #(.DEPTH(DEPTH), .COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .coord_x(coord_x), .coord_y(coord_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_x(read_x), .read_y(read_y), .entry_count(entry_count), .status(status)
  );

  plp_list_checker #(.DEPTH(DEPTH), .COORD_WIDTH(CW)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .coord_x(coord_x), .coord_y(coord_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_x(read_x), .read_y(read_y), .entry_count(entry_count), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output backpressure in bursts: mostly short, a few long, none while calm.
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(4, 16);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else if (r < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Picks a position: mostly inside the list, sometimes at its edges or beyond.
  function automatic int unsigned pick_pos(action_t act);
    int r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (act == ACT_INSERT) ? list_len : list_len - 1;
    if (r < 8) return $urandom_range(0, 127);
    if (r < 14) return (act == ACT_INSERT) ? list_len + 1 : list_len;
    if (act != ACT_INSERT && list_len == 0) return 0;
    if (r < 22) return 0;
    if (r < 30) return top;
    return $urandom_range(0, top);
  endfunction

  task automatic send_op(action_t act, int unsigned pos, logic [CW-1:0] cx,
                         logic [CW-1:0] cy);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    position <= pos[PW-1:0];
    coord_x  <= cx;
    coord_y  <= cy;
    do @(posedge clk); while (in_stall);
    // Track the length only to steer positions toward useful values.
    case (act)
      ACT_INSERT: if (pos <= list_len && list_len < DEPTH) list_len++;
      ACT_APPEND: if (list_len < DEPTH) list_len++;
      ACT_DELETE: if (pos < list_len) list_len--;
      default: ;
    endcase
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_op(int kind);
    int r;
    action_t act;
    r = $urandom_range(0, 99);
    case (kind)
      0:       act = (r < 40) ? ACT_INSERT : (r < 70) ? ACT_APPEND :
                     (r < 85) ? ACT_READ : ACT_DELETE;
      1:       act = (r < 50) ? ACT_DELETE : (r < 70) ? ACT_READ :
                     (r < 85) ? ACT_INSERT : ACT_APPEND;
      default: act = action_t'(r % 4);
    endcase
    send_op(act, (act == ACT_APPEND) ? $urandom_range(0, 127) : pick_pos(act),
            rand_coord(), rand_coord());
  endtask

  initial begin
    int phase_len;
    int kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every read and delete is out of range, as is an insert past the end.
    send_op(ACT_READ,   0, '0, '0);
    send_op(ACT_DELETE, 0, '0, '0);
    send_op(ACT_INSERT, 1, 32'h1234_5678, 32'h9abc_def0);
    send_op(ACT_INSERT, 0, 32'h7fff_ffff, 32'h8000_0000);
    send_op(ACT_APPEND, 127, 32'h8000_0000, 32'h7fff_ffff);
    send_op(ACT_INSERT, 1, '0, '1);
    send_op(ACT_INSERT, 3, '1, '0);
    for (int i = 0; i < 4; i++) send_op(ACT_READ, i, '0, '0);
    send_op(ACT_READ,   4, '0, '0);
    send_op(ACT_READ,   127, '0, '0);
    send_op(ACT_DELETE, 1, '0, '0);
    send_op(ACT_DELETE, 3, '0, '0);
    send_op(ACT_DELETE, 127, '0, '0);
    send_op(ACT_INSERT, 127, 32'h5555_5555, 32'haaaa_aaaa);
    send_op(ACT_INSERT, 3, 32'haaaa_aaaa, 32'h5555_5555);
    for (int i = 0; i < 3; i++) send_op(ACT_READ, i, '0, '0);

    // Hold the input until every outstanding result has come back.
    drain_results();

    // Fill the list, then try to grow it past full.
    while (list_len < DEPTH) begin
      if ($urandom_range(0, 1)) send_op(ACT_APPEND, $urandom_range(0, 127),
                                        rand_coord(), rand_coord());
      else send_op(ACT_INSERT, $urandom_range(0, list_len), rand_coord(), rand_coord());
    end
    send_op(ACT_INSERT, DEPTH, rand_coord(), rand_coord());
    send_op(ACT_APPEND, 0, rand_coord(), rand_coord());
    send_op(ACT_INSERT, 0, rand_coord(), rand_coord());
    send_op(ACT_INSERT, DEPTH + 1, rand_coord(), rand_coord());
    send_op(ACT_READ,   DEPTH - 1, '0, '0);
    send_op(ACT_READ,   DEPTH, '0, '0);
    send_op(ACT_DELETE, DEPTH - 1, '0, '0);

    while (sent < NUM_ITEMS) begin
      kind      = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 60);
      calm      = ($urandom_range(0, 4) == 0);
      repeat (phase_len) random_op(kind);
      if ($urandom_range(0, 3) == 0) drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
